FILE: rtl/slww_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted LWW table package
// Shared types, request and status codes and small helper functions.
// ----------------------------------------------------------------------------
package slww_pkg;

  localparam int KEY_W = 56;

  typedef enum logic [1:0] {
    REQ_ACCEPT = 2'd0,
    REQ_WANTS  = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_DIGEST = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_STALE   = 2'd0,
    ST_WRITTEN = 2'd1,
    ST_INVALID = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  localparam logic [7:0]  LAYER_BASE = 8'd0;
  localparam logic [7:0]  LAYER_NODE = 8'd1;
  localparam logic [7:0]  BYTE_MASK  = 8'hFF;
  localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
  localparam int          ROW_BYTES  = 24;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [63:0]      stime;
    logic [31:0]      scount;
    logic [31:0]      swriter;
    logic             dead;
    logic [63:0]      data;
    logic [3:0]       len;
  } row_t;

  // Stamp a is strictly newer than stamp b (time, then counter, then node).
  function automatic logic stamp_newer(input logic [127:0] a, input logic [127:0] b);
    stamp_newer = a > b;
  endfunction

  // Keep only the bytes below the given length.
  function automatic logic [63:0] mask_payload(input logic [63:0] pay, input logic [7:0] len);
    logic [63:0] r;
    r = '0;
    for (int b = 0; b < 8; b++) begin
      if (8'(b) < len) begin
        r[8*b +: 8] = pay[8*b +: 8] & BYTE_MASK;
      end
    end
    mask_payload = r;
  endfunction

endpackage

FILE: rtl/slww_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row store
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module slww_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic           clk,
  input  logic           rd_en,
  input  logic [AW-1:0]  rd_addr,
  output slww_pkg::row_t rd_data,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  slww_pkg::row_t wr_data
);
  import slww_pkg::*;

  row_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/slww_crc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-32 byte step
// Folds one byte into a reflected CRC-32 register value.
// ----------------------------------------------------------------------------
module slww_crc (
  input  logic [31:0] crc_in,
  input  logic [7:0]  data,
  output logic [31:0] crc_out
);
  import slww_pkg::*;

  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    crc_out = c;
  end

endmodule

FILE: rtl/sorted_lww_table_merge_top.sv
`timescale 1ns / 1ps
// Operation: a write or query scans the rows one at a time, reading then checking each row
// visited, and an insert moves each row above the insert point up one place; a digest reads
// each row and feeds its 24 bytes to the CRC unit one byte at a time.
// Flow: one transaction at a time; the next input is taken once the result is registered,
// and a previous result still held by the receiver holds the new one back.
// Reset: rst (synchronous) empties the table and sets table_limit to 64; the row store
// itself is not cleared, since rows at or above the fill count are never read.
// ----------------------------------------------------------------------------
// Sorted last-writer-wins table
// Keeps rows sorted by (layer, node, section) in a store with one read and one write port and
// serves accept, wants, effective lookup and digest requests with one
// sequencer, a shared stamp comparator and a byte-serial CRC unit.
// ----------------------------------------------------------------------------
module sorted_lww_table_merge_top #(
  parameter int TABLE_DEPTH   = 64,
  parameter int PAYLOAD_LIMIT = 8
) (
  input  logic         clk,
  input  logic         rst,
  // Configuration: table_limit.
  input  logic         cfg_we,
  input  logic [6:0]   cfg_wdata,
  // Request stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tuser: req_type[1:0]
  input  logic [1:0]   s_axis_tuser,
  // tdata from bit 0: key_layer(8) key_node_id(32) key_section(16) stamp_time(64)
  // stamp_counter(32) stamp_node(32) is_tombstone(1) payload_bytes(64)
  // payload_length(8), zero fill to 264 bits.
  input  logic [263:0] s_axis_tdata,
  // Result stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tuser: status[1:0]
  output logic [1:0]   m_axis_tuser,
  // tdata from bit 0: wanted(1) hit(1) hit_from_base(1) row_payload_out(64)
  // row_length_out(4) digest_crc(32) newest_time(64) newest_counter(32)
  // newest_node(32), zero fill to 232 bits.
  output logic [231:0] m_axis_tdata
);
  import slww_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int LW = (CW > 7) ? CW : 7;

  // One-hot sequencer states.
  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_SCAN_RD  = 11'b000_0000_0010,
    S_SCAN_CK  = 11'b000_0000_0100,
    S_RESOLVE  = 11'b000_0000_1000,
    S_SHIFT_RD = 11'b000_0001_0000,
    S_SHIFT_WR = 11'b000_0010_0000,
    S_WRITE    = 11'b000_0100_0000,
    S_DG_RD    = 11'b000_1000_0000,
    S_DG_LOAD  = 11'b001_0000_0000,
    S_DG_CRC   = 11'b010_0000_0000,
    S_OUT      = 11'b100_0000_0000
  } state_t;

  state_t state;

  // Incoming fields unpacked.
  logic [7:0]  in_layer;
  logic [31:0] in_node;
  logic [15:0] in_section;
  logic [63:0] in_time;
  logic [31:0] in_count;
  logic [31:0] in_snode;
  logic        in_tomb;
  logic [63:0] in_pay;
  logic [7:0]  in_len;
  req_t        in_req;

  assign in_layer   = s_axis_tdata[7:0];
  assign in_node    = s_axis_tdata[39:8];
  assign in_section = s_axis_tdata[55:40];
  assign in_time    = s_axis_tdata[119:56];
  assign in_count   = s_axis_tdata[151:120];
  assign in_snode   = s_axis_tdata[183:152];
  assign in_tomb    = s_axis_tdata[184];
  assign in_pay     = s_axis_tdata[248:185];
  assign in_len     = s_axis_tdata[256:249];
  assign in_req     = req_t'(s_axis_tuser);

  // Registers holding the request in progress.
  req_t             req;
  logic [KEY_W-1:0] tkey;
  logic [127:0]     tstamp;
  row_t             new_row;
  logic [15:0]      section;
  logic             lk_base;

  // Table state.
  logic [6:0]     table_limit;
  logic [CW-1:0]  row_count;
  logic [CW-1:0]  idx;
  logic [CW-1:0]  pos;
  logic           found;

  // Digest working registers.
  logic [31:0]     crc;
  logic [191:0]    dg_bytes;
  logic [4:0]      dg_cnt;
  logic [127:0]    newest;

  // Result being built and the output register.
  status_t     res_status;
  logic        res_wanted;
  logic        res_hit;
  logic        res_base;
  logic [63:0] res_pay;
  logic [3:0]  res_len;
  logic [31:0] res_crc;

  // Memory port.
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  row_t          rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  row_t          wr_data;

  slww_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  logic [31:0] crc_next;

  slww_crc u_crc (
    .crc_in  (crc),
    .data    (dg_bytes[7:0]),
    .crc_out (crc_next)
  );

  // Shared stamp comparator: the request stamp against the row just read,
  // or during a digest the row against the newest stamp so far.
  logic [127:0] rd_stamp;
  logic [127:0] cmp_a;
  logic [127:0] cmp_b;
  logic         cmp_newer;

  assign rd_stamp  = {rd_data.stime, rd_data.scount, rd_data.swriter};
  assign cmp_a     = (state == S_DG_LOAD) ? rd_stamp : tstamp;
  assign cmp_b     = (state == S_DG_LOAD) ? newest : rd_stamp;
  assign cmp_newer = stamp_newer(cmp_a, cmp_b);

  // The table is full when the fill count reaches the limit in force or the store depth.
  logic table_full;
  assign table_full = (LW'(row_count) >= LW'(table_limit)) ||
                      (row_count == CW'(TABLE_DEPTH));

  // Key and write validity, checked on the incoming transaction.
  logic key_ok;
  logic unset;
  logic write_bad;

  assign key_ok = ((in_layer == LAYER_BASE) && (in_node == 32'd0)) ||
                  ((in_layer == LAYER_NODE) && (in_node != 32'd0));
  assign unset  = (in_time == 64'd0) && (in_count == 32'd0) && (in_snode == 32'd0);
  assign write_bad = (in_len > 8'(PAYLOAD_LIMIT)) || (in_tomb && (in_len != 8'd0)) ||
                     (!in_tomb && (in_len == 8'd0)) || !key_ok ||
                     ((in_layer == LAYER_BASE) && in_tomb) || unset;

  assign s_axis_tready = (state == S_IDLE);

  // Memory port control.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = pos[AW-1:0];
    wr_data = new_row;
    unique case (state)
      S_SCAN_RD, S_DG_RD: begin
        rd_en   = (idx != row_count);
        rd_addr = idx[AW-1:0];
      end
      S_SHIFT_RD: begin
        rd_en   = (idx != pos);
        rd_addr = AW'(idx - CW'(1));
      end
      S_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx[AW-1:0];
        wr_data = rd_data;
      end
      S_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = pos[AW-1:0];
        wr_data = new_row;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      table_limit   <= 7'd64;
      row_count     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        table_limit <= cfg_wdata;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            req     <= in_req;
            tkey    <= {in_layer, in_node, in_section};
            tstamp  <= {in_time, in_count, in_snode};
            section <= in_section;
            lk_base <= 1'b0;
            new_row <= '{key: {in_layer, in_node, in_section}, stime: in_time,
                         scount: in_count, swriter: in_snode, dead: in_tomb,
                         data: mask_payload(in_pay, in_len), len: in_len[3:0]};
            idx        <= '0;
            res_status <= ST_STALE;
            res_wanted <= 1'b0;
            res_hit    <= 1'b0;
            res_base   <= 1'b0;
            res_pay    <= '0;
            res_len    <= '0;
            res_crc    <= '0;
            crc        <= CRC_INIT;
            newest     <= '0;
            unique case (in_req)
              REQ_ACCEPT: begin
                if (write_bad) begin
                  res_status <= ST_INVALID;
                  state      <= S_OUT;
                end else begin
                  state <= S_SCAN_RD;
                end
              end
              REQ_WANTS: state <= (key_ok && !unset) ? S_SCAN_RD : S_OUT;
              REQ_LOOKUP: begin
                tkey  <= {LAYER_NODE, in_node, in_section};
                state <= S_SCAN_RD;
              end
              REQ_DIGEST: state <= S_DG_RD;
            endcase
          end
        end

        // Linear scan for the key or its sorted place.
        S_SCAN_RD: begin
          if (idx == row_count) begin
            found <= 1'b0;
            pos   <= idx;
            state <= S_RESOLVE;
          end else begin
            state <= S_SCAN_CK;
          end
        end
        S_SCAN_CK: begin
          if (rd_data.key == tkey) begin
            found <= 1'b1;
            pos   <= idx;
            state <= S_RESOLVE;
          end else if (tkey < rd_data.key) begin
            found <= 1'b0;
            pos   <= idx;
            state <= S_RESOLVE;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_SCAN_RD;
          end
        end

        S_RESOLVE: begin
          unique case (req)
            REQ_ACCEPT: begin
              if (found) begin
                if (cmp_newer) begin
                  state <= S_WRITE;
                end else begin
                  res_status <= ST_STALE;
                  state      <= S_OUT;
                end
              end else if (table_full) begin
                res_status <= ST_FULL;
                state      <= S_OUT;
              end else begin
                idx   <= row_count;
                state <= S_SHIFT_RD;
              end
            end
            REQ_WANTS: begin
              res_wanted <= found ? cmp_newer : !table_full;
              state      <= S_OUT;
            end
            default: begin
              if (found && !rd_data.dead) begin
                res_hit  <= 1'b1;
                res_base <= lk_base;
                res_pay  <= rd_data.data;
                res_len  <= rd_data.len;
                state    <= S_OUT;
              end else if (!lk_base) begin
                lk_base <= 1'b1;
                tkey    <= {LAYER_BASE, 32'd0, section};
                idx     <= '0;
                state   <= S_SCAN_RD;
              end else begin
                state <= S_OUT;
              end
            end
          endcase
        end

        // Move rows up one place, from the end down to the insert point.
        S_SHIFT_RD: begin
          if (idx == pos) begin
            row_count <= row_count + CW'(1);
            state     <= S_WRITE;
          end else begin
            state <= S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          idx   <= idx - CW'(1);
          state <= S_SHIFT_RD;
        end

        S_WRITE: begin
          res_status <= ST_WRITTEN;
          state      <= S_OUT;
        end

        // Digest walk: read a row, then feed its 24 bytes to the CRC unit.
        S_DG_RD: begin
          if (idx == row_count) begin
            res_crc <= (row_count == '0) ? 32'd0 : ~crc;
            state   <= S_OUT;
          end else begin
            state <= S_DG_LOAD;
          end
        end
        S_DG_LOAD: begin
          dg_bytes <= {7'd0, rd_data.dead, rd_data.swriter, rd_data.scount,
                       rd_data.stime, rd_data.key[15:0], rd_data.key[47:16],
                       rd_data.key[55:48]};
          if (cmp_newer) begin
            newest <= rd_stamp;
          end
          dg_cnt <= '0;
          state  <= S_DG_CRC;
        end
        S_DG_CRC: begin
          crc      <= crc_next;
          dg_bytes <= dg_bytes >> 8;
          dg_cnt   <= dg_cnt + 5'd1;
          if (dg_cnt == 5'(ROW_BYTES - 1)) begin
            idx   <= idx + CW'(1);
            state <= S_DG_RD;
          end
        end

        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register, loaded as the result is handed over. The newest stamp
  // is held as {time, counter, node} but leaves with time in the lowest bits.
  always_ff @(posedge clk) begin
    if ((state == S_OUT) && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tuser <= res_status;
      m_axis_tdata <= {1'b0, newest[31:0], newest[63:32], newest[127:64], res_crc,
                       res_len, res_pay, res_base, res_hit, res_wanted};
    end
  end

endmodule

FILE: rtl/slww_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted LWW table port checker
// Watches the top level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module slww_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [1:0]   m_axis_tuser,
  input logic [231:0] m_axis_tdata
);
  import slww_pkg::*;

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // One transaction at a time: the input closes after each accepted one.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input still open after a transaction");

  // An invalid write reports nothing else.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_INVALID) |-> (m_axis_tdata == '0))
    else $error("invalid result carries data");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result pending after reset");

endmodule

bind sorted_lww_table_merge_top slww_checker u_slww_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tdata  (m_axis_tdata)
);
